// ===== hdl/bba_pkg.sv =====
package bba_pkg;

    localparam int MAX_BLOCKS  = 65536;
    localparam int CHUNK_BYTES = 4096;

    localparam int WORD_BITS   = 64;
    localparam int WORDS       = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORDS);
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int CHUNK_WORDS = CHUNK_BYTES * 8 / WORD_BITS;

    localparam int OP_W        = 2;
    localparam int BLOCK_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int CHUNKS_W    = 2;
    localparam int CFG_W       = 17;
    localparam int CFG_INDEX_W = 1;

    localparam int SPAN_RAW_W  = $clog2(((1 << CHUNKS_W) - 1) * CHUNK_WORDS + 1);
    localparam int SPAN_W      = (SPAN_RAW_W > WORD_AW + 1) ? SPAN_RAW_W : WORD_AW + 1;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_BLOCKS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BITMAP_CHUNKS = 1'b1;

    localparam logic [COUNT_W-1:0]  TOTAL_RESET  = 17'd65536;
    localparam logic [CHUNKS_W-1:0] CHUNKS_RESET = 2'd2;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic scan_first;
        logic scan_next;
        logic tgt_rd;
        logic alloc_commit;
        logic rmw_commit;
        logic fail;
    } bba_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            clear_last;
        logic            alloc_ok;
        logic            tgt_ok;
        logic            has_clear;
        logic            found_ok;
        logic            last_word;
    } bba_status_t;

endpackage

// ===== hdl/bitmap_block_allocator_unit.sv =====
// First-fit bitmap allocator over 65536 blocks, kept as 1024 words of 64 bits in one
// single-port-read memory. After reset the unit holds busy high while it clears the
// bitmap one word per cycle; configuration writes are taken during that time. A request
// is transferred when start is high and busy is low. Free and reserve read the target
// word in decode and write it back modified in the RMW state (read, modify, write of
// one word). Allocate reads one bitmap word per cycle from the lowest word up, at most
// 512 words with one chunk and 1024 with two or three, and stops at the first word with
// a clear bit; a request that fails its up-front checks answers straight from decode.
// The result is shown for exactly one cycle with done high and must be taken then, the
// receiver cannot stall it; blocks_in_use always shows the current used count. A new
// request can be transferred in the same cycle the previous result is shown.
module bitmap_block_allocator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bba_pkg::OP_W-1:0]          opcode,
    input  logic [bba_pkg::BLOCK_W-1:0]       target_block,
    input  logic                              cfg_we,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]         cfg_data,
    output logic                              done,
    output logic                              success,
    output logic [bba_pkg::BLOCK_W-1:0]       granted_block,
    output logic [bba_pkg::COUNT_W-1:0]       blocks_in_use
);
    import bba_pkg::*;

    bba_cmd_t    cmd;
    bba_status_t status;

    bba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bba_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .target_block  (target_block),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .success       (success),
        .granted_block (granted_block),
        .blocks_in_use (blocks_in_use)
    );

endmodule

// ===== hdl/bba_ctrl.sv =====
module bba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bba_pkg::bba_status_t status,
    output bba_pkg::bba_cmd_t    cmd,
    output logic                 busy
);
    import bba_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_RMW    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.op)
                    OP_ALLOC:
                    begin
                        if (status.alloc_ok)
                        begin
                            cmd.scan_first = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        else
                        begin
                            cmd.fail   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    OP_FREE, OP_RESERVE:
                    begin
                        if (status.tgt_ok)
                        begin
                            cmd.tgt_rd = 1'b1;
                            state_next = ST_RMW;
                        end
                        else
                        begin
                            cmd.fail   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.fail   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                priority if (status.has_clear)
                begin
                    cmd.alloc_commit = status.found_ok;
                    cmd.fail         = !status.found_ok;
                    state_next       = ST_IDLE;
                end
                else if (status.last_word)
                begin
                    cmd.fail   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_RMW:
            begin
                cmd.rmw_commit = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hdl/bba_datapath.sv =====
module bba_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bba_pkg::bba_cmd_t                 cmd,
    output bba_pkg::bba_status_t              status,
    input  logic [bba_pkg::OP_W-1:0]          opcode,
    input  logic [bba_pkg::BLOCK_W-1:0]       target_block,
    input  logic                              cfg_we,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]         cfg_data,
    output logic                              done,
    output logic                              success,
    output logic [bba_pkg::BLOCK_W-1:0]       granted_block,
    output logic [bba_pkg::COUNT_W-1:0]       blocks_in_use
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];

    logic [COUNT_W-1:0]   total_reg;
    logic [CHUNKS_W-1:0]  chunks_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [OP_W-1:0]      op_reg;
    logic [BLOCK_W-1:0]   tgt_reg;
    logic [WORD_AW-1:0]   addr_reg;
    logic [WORD_AW-1:0]   rd_word_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 done_reg;
    logic                 success_reg;
    logic [BLOCK_W-1:0]   granted_reg;

    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WORD_AW-1:0]   mem_raddr;

    logic [WORD_BITS-1:0] inv;
    logic [7:0]           byte_any;
    logic [2:0]           byte_sel;
    logic [7:0]           byte_val;
    logic [2:0]           bit_sel;
    logic [BIT_AW-1:0]    found_bit;
    logic [BLOCK_W-1:0]   found_n;
    logic [WORD_BITS-1:0] found_mask;
    logic [WORD_BITS-1:0] tgt_mask;
    logic                 tgt_used;
    logic [SPAN_W-1:0]    span_words;
    logic [SPAN_W-1:0]    limit_words;
    logic [SPAN_W-1:0]    next_word;
    logic                 count_full;

    // lowest clear bit: byte first, then bit within the byte
    always_comb
    begin
        inv      = ~rdata_reg;
        byte_sel = '0;
        bit_sel  = '0;
        for (int i = 0; i < 8; i++)
        begin
            byte_any[i] = |inv[i*8 +: 8];
        end
        for (int i = 7; i >= 0; i--)
        begin
            if (byte_any[i])
            begin
                byte_sel = 3'(i);
            end
        end
        byte_val = inv[byte_sel*8 +: 8];
        for (int i = 7; i >= 0; i--)
        begin
            if (byte_val[i])
            begin
                bit_sel = 3'(i);
            end
        end
        found_bit = {byte_sel, bit_sel};
    end

    assign found_n     = {rd_word_reg, found_bit};
    assign found_mask  = WORD_BITS'(1) << found_bit;
    assign tgt_mask    = WORD_BITS'(1) << tgt_reg[BIT_AW-1:0];
    assign tgt_used    = rdata_reg[tgt_reg[BIT_AW-1:0]];
    assign span_words  = SPAN_W'(chunks_reg) * SPAN_W'(CHUNK_WORDS);
    assign limit_words = (span_words > SPAN_W'(WORDS)) ? SPAN_W'(WORDS) : span_words;
    assign next_word   = SPAN_W'(rd_word_reg) + SPAN_W'(1);
    assign count_full  = (count_reg == {COUNT_W{1'b1}});

    always_comb
    begin
        status.op         = op_reg;
        status.clear_last = (addr_reg == WORD_AW'(WORDS - 1));
        status.alloc_ok   = (count_reg < total_reg) && (limit_words != '0);
        status.tgt_ok     = (COUNT_W'(tgt_reg) < total_reg);
        status.has_clear  = |inv;
        status.found_ok   = (COUNT_W'(found_n) < total_reg);
        status.last_word  = (next_word >= limit_words);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.clr_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.alloc_commit)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_word_reg;
            mem_wdata = rdata_reg | found_mask;
        end
        else if (cmd.rmw_commit)
        begin
            mem_we    = 1'b1;
            mem_waddr = tgt_reg[BLOCK_W-1:BIT_AW];
            mem_wdata = (op_reg == OP_FREE) ? (rdata_reg & ~tgt_mask) : (rdata_reg | tgt_mask);
        end

        mem_re    = cmd.scan_first | cmd.scan_next | cmd.tgt_rd;
        mem_raddr = '0;
        if (cmd.scan_next)
        begin
            mem_raddr = rd_word_reg + WORD_AW'(1);
        end
        else if (cmd.tgt_rd)
        begin
            mem_raddr = tgt_reg[BLOCK_W-1:BIT_AW];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.alloc_commit)
        begin
            if (!count_full)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
        else if (cmd.rmw_commit)
        begin
            if (op_reg == OP_FREE)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            else if (!tgt_used && !count_full)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= TOTAL_RESET;
            chunks_reg <= CHUNKS_RESET;
            count_reg  <= '0;
            addr_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOTAL_BLOCKS:  total_reg  <= cfg_data;
                    CFG_BITMAP_CHUNKS: chunks_reg <= cfg_data[CHUNKS_W-1:0];
                    default:           total_reg  <= total_reg;
                endcase
            end
            if (cmd.clr_wr)
            begin
                addr_reg <= addr_reg + WORD_AW'(1);
            end
            count_reg <= count_next;
            done_reg  <= cmd.alloc_commit | cmd.rmw_commit | cmd.fail;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            tgt_reg <= target_block;
        end
        if (cmd.scan_first)
        begin
            rd_word_reg <= '0;
        end
        else if (cmd.scan_next)
        begin
            rd_word_reg <= rd_word_reg + WORD_AW'(1);
        end
        success_reg <= cmd.alloc_commit | cmd.rmw_commit;
        granted_reg <= cmd.alloc_commit ? found_n : '0;
    end

    assign done          = done_reg;
    assign success       = success_reg;
    assign granted_block = granted_reg;
    assign blocks_in_use = count_reg;

endmodule

// ===== tb/bitmap_alloc_checker.sv =====
module bitmap_alloc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [bba_pkg::OP_W-1:0]          opcode,
    input  logic [bba_pkg::BLOCK_W-1:0]       target_block,
    input  logic                              cfg_we,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              done,
    input  logic                              success,
    input  logic [bba_pkg::BLOCK_W-1:0]       granted_block,
    input  logic [bba_pkg::COUNT_W-1:0]       blocks_in_use,
    output int                                mismatch_count,
    output int                                results_owed
);
    import bba_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [BLOCK_W-1:0] block;
        logic [COUNT_W-1:0] in_use;
    } op_result_t;

    logic [WORD_BITS-1:0] used_map [WORDS];
    logic [COUNT_W-1:0]   used_blocks;
    logic [COUNT_W-1:0]   total_limit;
    logic [CHUNKS_W-1:0]  chunk_count;
    op_result_t           pending_results[$];
    op_result_t           want;

    function automatic op_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [BLOCK_W-1:0] tgt);
        op_result_t r;
        int         span;
        int         w;
        int         b;
        int         n;
        logic       hit;
        r = '0;
        if (op == OP_ALLOC) begin
            span = int'(chunk_count) * CHUNK_BYTES * 8;
            if (span > MAX_BLOCKS)
                span = MAX_BLOCKS;
            hit = 1'b0;
            n = 0;
            // lowest clear bit inside the scanned span
            for (w = 0; w < WORDS && w * WORD_BITS < span && !hit; w++)
                if (used_map[w] != '1)
                    for (b = 0; b < WORD_BITS && !hit; b++)
                        if (!used_map[w][b])
                        begin
                            hit = 1'b1;
                            n = w * WORD_BITS + b;
                        end
            if (used_blocks < total_limit && hit && n < span && n < total_limit) begin
                used_map[n / WORD_BITS][n % WORD_BITS] = 1'b1;
                if (used_blocks != '1)
                    used_blocks = used_blocks + 1'b1;
                r.ok = 1'b1;
                r.block = BLOCK_W'(n);
            end
        end
        else if (op == OP_FREE || op == OP_RESERVE) begin
            if ({1'b0, tgt} < total_limit) begin
                r.ok = 1'b1;
                if (op == OP_FREE) begin
                    used_map[tgt[BLOCK_W-1:BIT_AW]][tgt[BIT_AW-1:0]] = 1'b0;
                    if (used_blocks != '0)
                        used_blocks = used_blocks - 1'b1;
                end
                else if (!used_map[tgt[BLOCK_W-1:BIT_AW]][tgt[BIT_AW-1:0]]) begin
                    used_map[tgt[BLOCK_W-1:BIT_AW]][tgt[BIT_AW-1:0]] = 1'b1;
                    if (used_blocks != '1)
                        used_blocks = used_blocks + 1'b1;
                end
            end
        end
        r.in_use = used_blocks;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < WORDS; i++)
                used_map[i] = '0;
            used_blocks = '0;
            total_limit = TOTAL_RESET;
            chunk_count = CHUNKS_RESET;
            pending_results.delete();
            mismatch_count = 0;
            results_owed = 0;
        end
        else begin
            // result transfer belongs to an earlier request
            if (done) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    mismatch_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (success !== want.ok) begin
                        $error("success: expected %0d, got %0d", want.ok, success);
                        mismatch_count++;
                    end
                    if (granted_block !== want.block) begin
                        $error("granted_block: expected %0d, got %0d",
                               want.block, granted_block);
                        mismatch_count++;
                    end
                    if (blocks_in_use !== want.in_use) begin
                        $error("blocks_in_use: expected %0d, got %0d",
                               want.in_use, blocks_in_use);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_TOTAL_BLOCKS)
                    total_limit = cfg_data[COUNT_W-1:0];
                else if (cfg_index == CFG_BITMAP_CHUNKS)
                    chunk_count = cfg_data[CHUNKS_W-1:0];
            end
            if (start && !busy)
                pending_results.push_back(apply_request(opcode, target_block));
            results_owed = pending_results.size();
        end
    end

endmodule

// ===== tb/tb_bitmap_block_allocator_unit.sv =====
module tb_bitmap_block_allocator_unit;
    import bba_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [OP_W-1:0]        opcode;
    logic [BLOCK_W-1:0]     target_block;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   done;
    logic                   success;
    logic [BLOCK_W-1:0]     granted_block;
    logic [COUNT_W-1:0]     blocks_in_use;

    int mismatch_count;
    int results_owed;
    int idle_pct;
    int cur_total;
    int idle_levels[3] = '{13, 77, 0};

    bitmap_block_allocator_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .target_block  (target_block),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .success       (success),
        .granted_block (granted_block),
        .blocks_in_use (blocks_in_use)
    );

    bitmap_alloc_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .target_block   (target_block),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .success        (success),
        .granted_block  (granted_block),
        .blocks_in_use  (blocks_in_use),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("tb_bitmap_block_allocator_unit failed");
        $finish;
    end

    task automatic drain();
        while (results_owed != 0) begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic configure(input int total, input int chunks);
        drain();
        start <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= CFG_TOTAL_BLOCKS;
        cfg_data <= CFG_W'(total);
        @(negedge clk);
        cfg_index <= CFG_BITMAP_CHUNKS;
        cfg_data <= CFG_W'(chunks);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_total = total;
    endtask

    // one request transfer, called and left at a falling edge
    task automatic issue(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] tgt);
        if ($urandom_range(99) == 0)
            while (results_owed != 0) begin
                start <= 1'b0;
                @(negedge clk);
            end
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        target_block <= tgt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_request();
        int                 r;
        logic [OP_W-1:0]    op;
        logic [BLOCK_W-1:0] tgt;
        r = $urandom_range(99);
        op = (r < 45) ? OP_ALLOC : (r < 70) ? OP_FREE : (r < 95) ? OP_RESERVE : OP_UNUSED;
        if ($urandom_range(4) == 0)
            tgt = BLOCK_W'($urandom);
        else
            tgt = BLOCK_W'($urandom_range(0, (cur_total > 65534) ? 65535 : cur_total + 1));
        issue(op, tgt);
    endtask

    task automatic random_setting();
        int t;
        case ($urandom_range(5))
            0: t = MAX_BLOCKS;
            1: t = 1;
            2: t = $urandom_range(2, 130);
            3: t = 64 + $urandom_range(0, 1);
            4: t = $urandom_range(131, 1000);
            default: t = $urandom_range(1001, 65535);
        endcase
        configure(t, $urandom_range(1, 3));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_ALLOC;
        target_block = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_TOTAL_BLOCKS;
        cfg_data = '0;
        idle_pct = 0;
        cur_total = MAX_BLOCKS;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        configure(MAX_BLOCKS, 2);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'hFFFF);
        issue(OP_RESERVE, 16'd3);
        issue(OP_RESERVE, 16'd3);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_FREE, 16'd1);
        issue(OP_FREE, 16'd1);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_RESERVE, 16'hFFFF);
        issue(OP_FREE, 16'hFFFF);
        issue(OP_UNUSED, 16'hFFFF);
        issue(OP_RESERVE, 16'h5555);
        issue(OP_RESERVE, 16'hAAAA);

        // small pool: out of range, full, free of a free block, beyond total
        configure(5, 1);
        issue(OP_RESERVE, 16'd5);
        issue(OP_FREE, 16'hFFFF);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_FREE, 16'd0);
        issue(OP_FREE, 16'd0);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);

        configure(MAX_BLOCKS, 3);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);
        configure(1, 2);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);

        foreach (idle_levels[k]) begin
            idle_pct = idle_levels[k];
            repeat (4) begin
                random_setting();
                repeat (48) random_request();
            end
        end

        // zero chunks: the scan span is empty
        idle_pct = 0;
        configure(MAX_BLOCKS, 0);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_RESERVE, 16'd0);
        configure(MAX_BLOCKS, 1);
        issue(OP_ALLOC, 16'h0000);

        drain();
        start <= 1'b0;
        repeat (1100) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("tb_bitmap_block_allocator_unit passed");
        else
            $display("tb_bitmap_block_allocator_unit failed");
        $finish;
    end

endmodule

// ===== bitmap_block_allocator_unit.f =====
hdl/bba_pkg.sv
hdl/bba_ctrl.sv
hdl/bba_datapath.sv
hdl/bitmap_block_allocator_unit.sv
tb/bitmap_alloc_checker.sv
tb/tb_bitmap_block_allocator_unit.sv
